/* rtl/i2cq_pkg.sv */
// Shared types and codes of the I2C master transaction queue.
package i2cq_pkg;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_LOAD    = 3'd2;
  localparam logic [2:0] CMD_BUS     = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;
  localparam logic [2:0] CMD_SERVICE = 3'd6;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_SEND     = 3'd2;
  localparam logic [2:0] ACT_READ_ACK = 3'd3;
  localparam logic [2:0] ACT_READ_NAK = 3'd4;
  localparam logic [2:0] ACT_STOP     = 3'd5;
  localparam logic [2:0] ACT_RESTART  = 3'd6;

  localparam logic [3:0] MAX_ERR_RESET = 4'd3;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_SLA,
    EV_REG,
    EV_DATA_ACK,
    EV_RD_ADDR,
    EV_RD_ACK,
    EV_RD_LAST,
    EV_ARB,
    EV_NACK
  } ev_e;

  typedef struct packed {
    logic [2:0] cmd;
    ev_e        ev;
    logic       len_ok;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] len;
    logic [7:0] tid;
    logic [3:0] idx;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] new_id;
    logic       done_res;
    logic       successful;
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_id;
    logic [3:0] read_index;
    logic [7:0] read_data;
  } res_t;

endpackage

/* rtl/i2cq_ram.sv */
// Generic RAM with one write port and one registered read port.
module i2cq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/i2cq_front.sv */
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
module i2cq_front #(
  parameter int MAX_BYTES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [6:0]         device_address_i,
  input  logic [7:0]         register_address_i,
  input  logic [7:0]         length_i,
  input  logic [7:0]         transaction_id_i,
  input  logic [3:0]         byte_index_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         bus_status_i,
  output logic               item_valid_o,
  input  logic               item_pop_i,
  output i2cq_pkg::item_t    item_o
);
  import i2cq_pkg::*;

  item_t      fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls;
  logic       push, pop, len_le;

  assign len_le = (9'(length_i) <= 9'(MAX_BYTES));

  always_comb begin
    cls.cmd      = command_i;
    cls.dev      = device_address_i;
    cls.reg_addr = register_address_i;
    cls.len      = length_i;
    cls.tid      = transaction_id_i;
    cls.idx      = byte_index_i;
    cls.data     = data_byte_i;
    cls.len_ok   = len_le && (command_i == CMD_WRITE || length_i != 8'd0);
    case (bus_status_i[7:3])
      5'd1, 5'd2: cls.ev = EV_SLA;
      5'd3:       cls.ev = EV_REG;
      5'd5:       cls.ev = EV_DATA_ACK;
      5'd8:       cls.ev = EV_RD_ADDR;
      5'd10:      cls.ev = EV_RD_ACK;
      5'd11:      cls.ev = EV_RD_LAST;
      5'd7:       cls.ev = EV_ARB;
      5'd4, 5'd6, 5'd9: cls.ev = EV_NACK;
      default:    cls.ev = EV_NONE;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = fifo_q[rptr_q];

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/i2cq_back.sv */
// Back end: slot ring, scanning sequencer, write byte store and result register.
module i2cq_back #(
  parameter int QUEUE_SLOTS = 8,
  parameter int MAX_BYTES   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      max_err_i,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  input  i2cq_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output i2cq_pkg::res_t  out_o
);
  import i2cq_pkg::*;

  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int DEPTH = QUEUE_SLOTS * MAX_BYTES;
  localparam int AW = $clog2(DEPTH);
  localparam logic [SW-1:0] LAST = SW'(QUEUE_SLOTS - 1);

  localparam int FL_WRITE = 0;
  localparam int FL_ACT   = 1;
  localparam int FL_REG   = 2;
  localparam int FL_DONE  = 3;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUB   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_FIND  = 3'd3;
  localparam logic [2:0] ST_BUS   = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_DLV   = 3'd6;

  logic [7:0]    ident_q [QUEUE_SLOTS];
  logic [3:0]    flags_q [QUEUE_SLOTS];
  logic [6:0]    dev_q   [QUEUE_SLOTS];
  logic [7:0]    regs_q  [QUEUE_SLOTS];
  logic [CW-1:0] count_q [QUEUE_SLOTS];
  logic [CW-1:0] prog_q  [QUEUE_SLOTS];
  logic [3:0]    err_q   [QUEUE_SLOTS];

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] ptr_q, ptr_d, n_q, n_d, head_q, head_d, ptr_inc;
  logic [7:0]    idc_q, idc_d;
  logic          fin_q, fin_d;
  item_t         item_q, item_d;
  res_t          res_q, res_d, out_q, out_d;
  logic          ovld_q, ovld_d;

  logic [7:0]    id_c;
  logic [3:0]    fl_c, fl_w, err_c, err_w;
  logic [CW-1:0] cnt_c, prog_c, prog_w;
  logic [8:0]    prog_ext, prog_nx;
  logic          slot_we, ident_we, flags_we, prog_we, err_we, cand;
  logic [7:0]    ident_w;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  assign id_c     = ident_q[ptr_q];
  assign fl_c     = flags_q[ptr_q];
  assign err_c    = err_q[ptr_q];
  assign cnt_c    = count_q[ptr_q];
  assign prog_c   = prog_q[ptr_q];
  assign prog_ext = 9'(prog_c);
  assign ptr_inc  = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
  assign cand     = (id_c != 8'd0) && !fl_c[FL_ACT] && !fl_c[FL_DONE];

  assign ram_waddr = AW'(int'(ptr_q) * MAX_BYTES + int'(item_q.idx));
  assign ram_raddr = AW'(int'(ptr_q) * MAX_BYTES + int'(prog_c));

  i2cq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_q.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    n_d       = n_q;
    head_d    = head_q;
    idc_d     = idc_q;
    fin_d     = fin_q;
    item_d    = item_q;
    res_d     = res_q;
    out_d     = out_q;
    ovld_d    = ovld_q && out_stall_i;
    item_pop_o = 1'b0;
    slot_we   = 1'b0;
    ident_we  = 1'b0;
    ident_w   = 8'd0;
    flags_we  = 1'b0;
    fl_w      = fl_c;
    prog_we   = 1'b0;
    prog_w    = prog_c;
    err_we    = 1'b0;
    err_w     = err_c;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    prog_nx   = prog_ext;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          res_d      = '0;
          n_d        = '0;
          fin_d      = 1'b0;
          state_d    = ST_DLV;
          case (item_i.cmd)
            CMD_WRITE, CMD_READ: begin
              if (item_i.len_ok) begin
                ptr_d   = head_q;
                state_d = ST_SUB;
              end
            end
            CMD_LOAD, CMD_QUERY, CMD_CLEAR: begin
              if (item_i.tid == 8'd0) begin
                if (item_i.cmd == CMD_QUERY) begin
                  res_d.done_res   = 1'b1;
                  res_d.successful = 1'b1;
                end
              end else begin
                ptr_d   = '0;
                state_d = ST_FIND;
              end
            end
            CMD_BUS: begin
              ptr_d   = head_q;
              state_d = ST_BUS;
            end
            CMD_SERVICE: begin
              ptr_d   = head_q;
              state_d = ST_START;
            end
            default: state_d = ST_DLV;
          endcase
        end
      end
      ST_SUB: begin
        if (id_c == 8'd0) begin
          slot_we        = 1'b1;
          ident_we       = 1'b1;
          ident_w        = idc_q;
          res_d.accepted = 1'b1;
          res_d.new_id   = idc_q;
          idc_d          = (idc_q == 8'hFF) ? 8'd1 : idc_q + 8'd1;
          ptr_d          = head_q;
          n_d            = '0;
          state_d        = ST_START;
        end else if (n_q == LAST) begin
          state_d = ST_DLV;
        end else begin
          ptr_d = ptr_inc;
          n_d   = n_q + 1'b1;
        end
      end
      ST_START: begin
        if ((n_q == '0 && fl_c[FL_ACT]) || (!cand && n_q == LAST)) begin
          res_d.bus_action = fin_q ? ACT_STOP : ACT_NONE;
          state_d          = ST_DLV;
        end else if (cand) begin
          head_d           = ptr_q;
          flags_we         = 1'b1;
          fl_w[FL_ACT]     = 1'b1;
          res_d.bus_action = fin_q ? ACT_RESTART : ACT_START;
          state_d          = ST_DLV;
        end else begin
          ptr_d = ptr_inc;
          n_d   = n_q + 1'b1;
        end
      end
      ST_FIND: begin
        if (id_c == item_q.tid) begin
          state_d = ST_DLV;
          case (item_q.cmd)
            CMD_LOAD: begin
              if (fl_c[FL_WRITE] && 9'(item_q.idx) < 9'(MAX_BYTES)) begin
                ram_we         = 1'b1;
                res_d.accepted = 1'b1;
              end
            end
            CMD_QUERY: begin
              res_d.done_res   = fl_c[FL_DONE];
              res_d.successful = (err_c < max_err_i);
            end
            default: begin
              if (!fl_c[FL_ACT]) begin
                ident_we       = 1'b1;
                res_d.accepted = 1'b1;
              end
            end
          endcase
        end else if (n_q == LAST) begin
          if (item_q.cmd == CMD_QUERY) begin
            res_d.done_res   = 1'b1;
            res_d.successful = 1'b1;
          end
          state_d = ST_DLV;
        end else begin
          ptr_d = ptr_inc;
          n_d   = n_q + 1'b1;
        end
      end
      ST_BUS: begin
        state_d = ST_DLV;
        if (fl_c[FL_ACT]) begin
          case (item_q.ev)
            EV_SLA: begin
              res_d.bus_action = ACT_SEND;
              res_d.bus_byte   = {dev_q[ptr_q], fl_c[FL_REG]};
            end
            EV_REG: begin
              res_d.bus_action = ACT_SEND;
              res_d.bus_byte   = regs_q[ptr_q];
            end
            EV_DATA_ACK: begin
              flags_we     = 1'b1;
              fl_w[FL_REG] = 1'b1;
              if (fl_c[FL_WRITE]) begin
                if (prog_c < cnt_c && prog_ext < 9'(MAX_BYTES)) begin
                  ram_re           = 1'b1;
                  prog_we          = 1'b1;
                  prog_w           = prog_c + 1'b1;
                  res_d.bus_action = ACT_SEND;
                  state_d          = ST_WAIT;
                end else begin
                  fl_w[FL_DONE] = 1'b1;
                  fl_w[FL_ACT]  = 1'b0;
                  fin_d         = 1'b1;
                  head_d        = ptr_inc;
                  ptr_d         = ptr_inc;
                  n_d           = '0;
                  state_d       = ST_START;
                end
              end else begin
                res_d.bus_action = ACT_START;
              end
            end
            EV_RD_ADDR: begin
              res_d.bus_action = (cnt_c != CW'(1)) ? ACT_READ_ACK : ACT_READ_NAK;
            end
            EV_RD_ACK, EV_RD_LAST: begin
              if (prog_c < cnt_c) begin
                res_d.read_valid = 1'b1;
                res_d.read_id    = id_c;
                res_d.read_index = prog_ext[3:0];
                res_d.read_data  = item_q.data;
                prog_we          = 1'b1;
                prog_w           = prog_c + 1'b1;
                prog_nx          = prog_ext + 9'd1;
              end
              if (item_q.ev == EV_RD_ACK) begin
                res_d.bus_action = (prog_nx + 9'd1 < 9'(cnt_c)) ? ACT_READ_ACK
                                                                 : ACT_READ_NAK;
              end else begin
                flags_we      = 1'b1;
                fl_w[FL_DONE] = 1'b1;
                fl_w[FL_ACT]  = 1'b0;
                fin_d         = 1'b1;
                head_d        = ptr_inc;
                ptr_d         = ptr_inc;
                n_d           = '0;
                state_d       = ST_START;
              end
            end
            EV_ARB, EV_NACK: begin
              err_we = 1'b1;
              err_w  = (err_c == 4'hF) ? err_c : err_c + 4'd1;
              if (err_w < max_err_i) begin
                flags_we         = 1'b1;
                fl_w[FL_REG]     = 1'b0;
                prog_we          = 1'b1;
                prog_w           = '0;
                res_d.bus_action = (item_q.ev == EV_ARB) ? ACT_RESTART : ACT_START;
              end else begin
                flags_we      = 1'b1;
                fl_w[FL_DONE] = 1'b1;
                fl_w[FL_ACT]  = 1'b0;
                fin_d         = (item_q.ev != EV_ARB);
                head_d        = ptr_inc;
                ptr_d         = ptr_inc;
                n_d           = '0;
                state_d       = ST_START;
              end
            end
            default: state_d = ST_DLV;
          endcase
        end
      end
      ST_WAIT: begin
        res_d.bus_byte = ram_rdata;
        state_d        = ST_DLV;
      end
      ST_DLV: begin
        if (!ovld_q || !out_stall_i) begin
          out_d   = res_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      dev_q[ptr_q]   <= item_q.dev;
      regs_q[ptr_q]  <= item_q.reg_addr;
      count_q[ptr_q] <= CW'(item_q.len);
      prog_q[ptr_q]  <= '0;
      err_q[ptr_q]   <= 4'd0;
    end else begin
      if (prog_we) begin
        prog_q[ptr_q] <= prog_w;
      end
      if (err_we) begin
        err_q[ptr_q] <= err_w;
      end
    end
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        ident_q[i] <= 8'd0;
        flags_q[i] <= 4'd0;
      end
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      n_q     <= '0;
      head_q  <= '0;
      idc_q   <= 8'd1;
      fin_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      if (ident_we) begin
        ident_q[ptr_q] <= ident_w;
      end
      if (slot_we) begin
        flags_q[ptr_q] <= {3'b000, item_q.cmd == CMD_WRITE};
      end else if (flags_we) begin
        flags_q[ptr_q] <= fl_w;
      end
      state_q <= state_d;
      ptr_q   <= ptr_d;
      n_q     <= n_d;
      head_q  <= head_d;
      idc_q   <= idc_d;
      fin_q   <= fin_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_o       = out_q;

endmodule

/* rtl/i2c_master_transaction_queue_unit.sv */
// Top level of the I2C master transaction queue: front queue, back sequencer, config register.
// A submit, an ID lookup and a bus event that ends a transaction scan the slot ring, which
// visits one slot per cycle; a write byte send also waits for the registered byte store read.
// Throughput: one request at a time in the back end; a two-entry queue takes requests meanwhile.
// Reset clears all slots to free, the ID counter to one and max_errors to three.
module i2c_master_transaction_queue_unit #(
  parameter int QUEUE_SLOTS = 8,
  parameter int MAX_BYTES   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [6:0] device_address_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] length_i,
  input  logic [7:0] transaction_id_i,
  input  logic [3:0] byte_index_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] bus_status_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic [7:0] new_id_o,
  output logic       done_res_o,
  output logic       successful_o,
  output logic [2:0] bus_action_o,
  output logic [7:0] bus_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_id_o,
  output logic [3:0] read_index_o,
  output logic [7:0] read_data_o
);
  import i2cq_pkg::*;

  logic [3:0] max_err_q;
  logic       item_valid, item_pop;
  item_t      item;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_err_q <= MAX_ERR_RESET;
    end else if (cfg_we_i) begin
      max_err_q <= cfg_data_i;
    end
  end

  i2cq_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .length_i           (length_i),
    .transaction_id_i   (transaction_id_i),
    .byte_index_i       (byte_index_i),
    .data_byte_i        (data_byte_i),
    .bus_status_i       (bus_status_i),
    .item_valid_o       (item_valid),
    .item_pop_i         (item_pop),
    .item_o             (item)
  );

  i2cq_back #(.QUEUE_SLOTS(QUEUE_SLOTS), .MAX_BYTES(MAX_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_err_i    (max_err_q),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign accepted_o   = res.accepted;
  assign new_id_o     = res.new_id;
  assign done_res_o   = res.done_res;
  assign successful_o = res.successful;
  assign bus_action_o = res.bus_action;
  assign bus_byte_o   = res.bus_byte;
  assign read_valid_o = res.read_valid;
  assign read_id_o    = res.read_id;
  assign read_index_o = res.read_index;
  assign read_data_o  = res.read_data;

endmodule

/* rtl/i2cq_checker.sv */
// Port-level checker for the I2C master transaction queue, bound to the top level.
module i2cq_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accepted_o,
  input logic [7:0] new_id_o,
  input logic       done_res_o,
  input logic       successful_o,
  input logic [2:0] bus_action_o,
  input logic       read_valid_o
);
  import i2cq_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_id_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_id_o != 8'd0 |-> accepted_o)
    else $error("new ID given without acceptance");

  a_read_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> bus_action_o == ACT_READ_ACK ||
      bus_action_o == ACT_READ_NAK || bus_action_o == ACT_STOP ||
      bus_action_o == ACT_RESTART)
    else $error("read byte delivered with a wrong bus action");

  a_query_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (done_res_o || successful_o) |-> !accepted_o &&
      bus_action_o == ACT_NONE && !read_valid_o)
    else $error("query answer mixed with other result fields");

endmodule

bind i2c_master_transaction_queue_unit i2cq_port_checker u_i2cq_checker (.*);

/* dv/i2cq_tb_pkg.sv */
// Bus status codes shared by the stimulus and the checker of the I2C transaction queue bench.
package i2cq_tb_pkg;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

endpackage

/* dv/i2cq_checker.sv */
// Predicts the responses of the I2C transaction queue and compares them with the block.
module i2cq_checker
  import i2cq_pkg::*;
  import i2cq_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] command_i,
  input  logic [6:0] device_address_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] length_i,
  input  logic [7:0] transaction_id_i,
  input  logic [3:0] byte_index_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] bus_status_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  res_t       got_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int BYTES = 16;
  localparam int F_WR = 0, F_ACT = 1, F_REG = 2, F_DONE = 3;

  logic [7:0] slot_id  [SLOTS];
  logic [7:0] slot_dev [SLOTS];
  logic [7:0] slot_reg [SLOTS];
  logic [4:0] slot_cnt [SLOTS];
  logic [4:0] slot_prog[SLOTS];
  logic [3:0] slot_err [SLOTS];
  logic [3:0] slot_fl  [SLOTS];
  logic [7:0] wr_bytes [SLOTS*BYTES];
  int         head;
  logic [7:0] next_id;
  logic [3:0] err_limit;
  res_t       resp;
  res_t       responses_due[$];

  assign pending_o = responses_due.size();

  function automatic int lookup(logic [7:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < SLOTS; i++) if (slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit launch();
    int i;
    i = head;
    if (slot_fl[i][F_ACT]) return 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_id[i] != 0 && !slot_fl[i][F_ACT] && !slot_fl[i][F_DONE]) begin
        head = i;
        slot_fl[i][F_ACT] = 1'b1;
        return 1;
      end
      i = (i + 1) % SLOTS;
    end
    return 0;
  endfunction

  function automatic void submit(bit is_wr, logic [6:0] dev, logic [7:0] ra, logic [7:0] len);
    int i, n;
    i = head;
    if (len > BYTES || (!is_wr && len == 0)) return;
    for (n = 0; n < SLOTS; n++) begin
      if (slot_id[i] == 0) break;
      i = (i + 1) % SLOTS;
    end
    if (n == SLOTS) return;
    slot_id[i] = next_id;
    resp.accepted = 1'b1;
    resp.new_id = next_id;
    next_id = next_id + 8'd1;
    if (next_id == 0) next_id = 8'd1;
    slot_dev[i] = {dev, 1'b0};
    slot_reg[i] = ra;
    slot_cnt[i] = len[4:0];
    slot_prog[i] = '0;
    slot_err[i] = '0;
    slot_fl[i] = is_wr ? 4'b0001 : 4'b0000;
    if (launch()) resp.bus_action = ACT_START;
  endfunction

  function automatic void finish(int s, bit arb);
    bit started;
    slot_fl[s][F_DONE] = 1'b1;
    slot_fl[s][F_ACT] = 1'b0;
    head = (s + 1) % SLOTS;
    started = launch();
    if (arb) resp.bus_action = started ? ACT_START : ACT_NONE;
    else resp.bus_action = started ? ACT_RESTART : ACT_STOP;
  endfunction

  function automatic void deliver(int s, logic [7:0] b);
    if (slot_prog[s] < slot_cnt[s]) begin
      resp.read_valid = 1'b1;
      resp.read_id = slot_id[s];
      resp.read_index = slot_prog[s][3:0];
      resp.read_data = b;
      slot_prog[s]++;
    end
  endfunction

  function automatic void bus_event(logic [7:0] st, logic [7:0] b);
    int s;
    bit arb;
    s = head;
    arb = 0;
    if (!slot_fl[s][F_ACT]) return;
    case (st)
      ST_START, ST_RESTART: begin
        resp.bus_action = ACT_SEND;
        resp.bus_byte = slot_fl[s][F_REG] ? (slot_dev[s] | 8'h01) : (slot_dev[s] & 8'hFE);
        return;
      end
      ST_SLAW_ACK: begin
        resp.bus_action = ACT_SEND;
        resp.bus_byte = slot_reg[s];
        return;
      end
      ST_DATA_ACK: begin
        slot_fl[s][F_REG] = 1'b1;
        if (slot_fl[s][F_WR]) begin
          if (slot_prog[s] < slot_cnt[s] && slot_prog[s] < BYTES) begin
            resp.bus_action = ACT_SEND;
            resp.bus_byte = wr_bytes[s*BYTES + slot_prog[s]];
            slot_prog[s]++;
          end else begin
            finish(s, 0);
          end
        end else begin
          resp.bus_action = ACT_START;
        end
        return;
      end
      ST_SLAR_ACK: begin
        resp.bus_action = (slot_cnt[s] != 1) ? ACT_READ_ACK : ACT_READ_NAK;
        return;
      end
      ST_RX_ACK: begin
        deliver(s, b);
        resp.bus_action = (int'(slot_prog[s]) + 1 < int'(slot_cnt[s])) ? ACT_READ_ACK
                                                                        : ACT_READ_NAK;
        return;
      end
      ST_RX_NACK: begin
        deliver(s, b);
        finish(s, 0);
        return;
      end
      ST_ARB_LOST: arb = 1;
      ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: arb = 0;
      default: return;
    endcase
    if (slot_err[s] < 4'd15) slot_err[s]++;
    if (slot_err[s] < err_limit) begin
      slot_fl[s][F_REG] = 1'b0;
      slot_prog[s] = '0;
      resp.bus_action = arb ? ACT_RESTART : ACT_START;
      return;
    end
    finish(s, arb);
  endfunction

  function automatic void predict();
    int s;
    resp = '0;
    case (command_i)
      CMD_WRITE: submit(1, device_address_i, register_address_i, length_i);
      CMD_READ:  submit(0, device_address_i, register_address_i, length_i);
      CMD_LOAD: begin
        s = lookup(transaction_id_i);
        if (s >= 0 && slot_fl[s][F_WR] && byte_index_i < BYTES) begin
          wr_bytes[s*BYTES + byte_index_i] = data_byte_i;
          resp.accepted = 1'b1;
        end
      end
      CMD_BUS: bus_event(bus_status_i & 8'hF8, data_byte_i);
      CMD_QUERY: begin
        s = lookup(transaction_id_i);
        resp.done_res = (s < 0) ? 1'b1 : slot_fl[s][F_DONE];
        resp.successful = (s < 0) ? 1'b1 : (slot_err[s] < err_limit);
      end
      CMD_CLEAR: begin
        s = lookup(transaction_id_i);
        if (s >= 0 && !slot_fl[s][F_ACT]) begin
          slot_id[s] = '0;
          resp.accepted = 1'b1;
        end
      end
      CMD_SERVICE: if (launch()) resp.bus_action = ACT_START;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i] = '0; slot_dev[i] = '0; slot_reg[i] = '0; slot_cnt[i] = '0;
        slot_prog[i] = '0; slot_err[i] = '0; slot_fl[i] = '0;
      end
      for (int i = 0; i < SLOTS*BYTES; i++) wr_bytes[i] = '0;
      head = 0;
      next_id = 8'd1;
      err_limit = MAX_ERR_RESET;
      responses_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) err_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        predict();
        responses_due.push_back(resp);
      end
      if (out_valid_i && !out_stall_i) begin
        if (responses_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Response with no request outstanding: %p", got_i);
        end else begin
          want = responses_due.pop_front();
          if (got_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch: expected acc=%0d id=%0d done=%0d ok=%0d act=%0d byte=%0h rv=%0d rid=%0d ridx=%0d rdata=%0h, actual acc=%0d id=%0d done=%0d ok=%0d act=%0d byte=%0h rv=%0d rid=%0d ridx=%0d rdata=%0h",
                want.accepted, want.new_id, want.done_res, want.successful, want.bus_action,
                want.bus_byte, want.read_valid, want.read_id, want.read_index, want.read_data,
                got_i.accepted, got_i.new_id, got_i.done_res, got_i.successful,
                got_i.bus_action, got_i.bus_byte, got_i.read_valid, got_i.read_id,
                got_i.read_index, got_i.read_data);
          end
        end
      end
    end
  end

endmodule

/* dv/i2c_master_transaction_queue_unit_tb.sv */
// Stimulus and verdict for the I2C master transaction queue unit.
module i2c_master_transaction_queue_unit_tb;
  import i2cq_pkg::*;
  import i2cq_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] command_i = '0;
  logic [6:0] device_address_i = '0;
  logic [7:0] register_address_i = '0;
  logic [7:0] length_i = '0;
  logic [7:0] transaction_id_i = '0;
  logic [3:0] byte_index_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [7:0] bus_status_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  res_t       got;
  int         fail_count;
  int         pending;
  bit         calm = 0;
  logic [7:0] recent_ids[16];
  int         recent_wp = 0;
  logic [7:0] status_codes[11] = '{ST_START, ST_RESTART, ST_SLAW_ACK, ST_SLAW_NACK,
                                   ST_DATA_ACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLAR_ACK,
                                   ST_SLAR_NACK, ST_RX_ACK, ST_RX_NACK};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  i2c_master_transaction_queue_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .command_i, .device_address_i, .register_address_i, .length_i, .transaction_id_i,
    .byte_index_i, .data_byte_i, .bus_status_i, .out_valid_o, .out_stall_i,
    .accepted_o(got.accepted), .new_id_o(got.new_id), .done_res_o(got.done_res),
    .successful_o(got.successful), .bus_action_o(got.bus_action), .bus_byte_o(got.bus_byte),
    .read_valid_o(got.read_valid), .read_id_o(got.read_id), .read_index_o(got.read_index),
    .read_data_o(got.read_data)
  );

  i2cq_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_i(in_stall_o),
    .command_i, .device_address_i, .register_address_i, .length_i, .transaction_id_i,
    .byte_index_i, .data_byte_i, .bus_status_i, .out_valid_i(out_valid_o), .out_stall_i,
    .got_i(got), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 6);

  always @(posedge clk_i)
    if (out_valid_o && !out_stall_i && got.accepted && got.new_id != 0) begin
      recent_ids[recent_wp] <= got.new_id;
      recent_wp <= (recent_wp + 1) % 16;
    end

  task automatic send(logic [2:0] cmd, logic [6:0] dev, logic [7:0] ra, logic [7:0] len,
                      logic [7:0] tid, logic [3:0] idx, logic [7:0] b, logic [7:0] st);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    device_address_i <= dev;
    register_address_i <= ra;
    length_i <= len;
    transaction_id_i <= tid;
    byte_index_i <= idx;
    data_byte_i <= b;
    bus_status_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic simple(logic [2:0] cmd, logic [7:0] len, logic [7:0] tid, logic [7:0] st);
    send(cmd, 7'($urandom), 8'($urandom), len, tid, 4'($urandom), 8'($urandom), st);
  endtask

  task automatic drain_and_config(logic [3:0] limit);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [7:0] len, tid, st;
    pick = $urandom_range(99);
    len = ($urandom_range(9) < 8) ? 8'($urandom_range(16, 1))
        : ($urandom_range(1) ? 8'd0 : 8'($urandom));
    tid = ($urandom_range(4) != 0) ? recent_ids[$urandom_range(15)] : 8'($urandom);
    st = ($urandom_range(6) != 0) ? status_codes[$urandom_range(10)] : 8'($urandom);
    if (pick < 10) simple(CMD_WRITE, len, tid, st);
    else if (pick < 20) simple(CMD_READ, len, tid, st);
    else if (pick < 33) simple(CMD_LOAD, len, tid, st);
    else if (pick < 78) simple(CMD_BUS, len, tid, st);
    else if (pick < 86) simple(CMD_QUERY, len, tid, st);
    else if (pick < 96) simple(CMD_CLEAR, len, tid, st);
    else if (pick < 99) simple(CMD_SERVICE, len, tid, st);
    else simple(CMD_UNUSED, len, tid, st);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) recent_ids[i] = 8'(i + 1);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill every slot with a full write and load every byte of the write store, so no
    // later write can send a byte that was never loaded; the ninth submit finds no slot.
    for (int i = 0; i < 9; i++) simple(CMD_WRITE, 8'd16, 8'd0, 8'd0);
    for (int i = 1; i <= 8; i++)
      for (int j = 0; j < 16; j++)
        send(CMD_LOAD, 7'd0, 8'd0, 8'd0, 8'(i), 4'(j), 8'($urandom), 8'd0);
    for (int i = 0; i < 24; i++) simple(CMD_BUS, 8'd0, 8'd0, ST_SLAW_NACK);
    for (int i = 1; i <= 8; i++) simple(CMD_CLEAR, 8'd0, 8'(i), 8'd0);

    simple(CMD_QUERY, 8'd0, 8'd0, 8'd0);
    simple(CMD_QUERY, 8'd0, 8'd200, 8'd0);
    simple(CMD_LOAD, 8'd0, 8'd0, 8'd0);
    simple(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
    simple(CMD_BUS, 8'd0, 8'd0, ST_START);
    simple(CMD_WRITE, 8'd17, 8'd0, 8'd0);
    simple(CMD_READ, 8'd0, 8'd0, 8'd0);
    simple(CMD_WRITE, 8'd255, 8'd0, 8'd0);
    simple(CMD_UNUSED, 8'd0, 8'd0, 8'd0);
    simple(CMD_SERVICE, 8'd0, 8'd0, 8'd0);
    simple(CMD_WRITE, 8'd0, 8'd0, 8'd0);
    simple(CMD_BUS, 8'd0, 8'd0, 8'hFF);
    simple(CMD_BUS, 8'd0, 8'd0, ST_DATA_ACK);
    simple(CMD_READ, 8'd1, 8'd0, 8'd0);
    simple(CMD_CLEAR, 8'd0, 8'd10, 8'd0);
    simple(CMD_BUS, 8'd0, 8'd0, ST_START);
    simple(CMD_BUS, 8'd0, 8'd0, ST_SLAW_ACK);
    simple(CMD_BUS, 8'd0, 8'd0, ST_DATA_ACK);
    simple(CMD_BUS, 8'd0, 8'd0, ST_RESTART);
    simple(CMD_BUS, 8'd0, 8'd0, ST_SLAR_ACK);
    simple(CMD_BUS, 8'd0, 8'd0, ST_RX_ACK);
    simple(CMD_BUS, 8'd0, 8'd0, ST_RX_ACK);
    simple(CMD_BUS, 8'd0, 8'd0, ST_ARB_LOST);
    simple(CMD_BUS, 8'd0, 8'd0, ST_RX_NACK);
    simple(CMD_QUERY, 8'd0, 8'd10, 8'd0);

    drain_and_config(4'd15);
    for (int i = 0; i < 400; i++) random_item();
    drain_and_config(4'd1);
    calm = 1;
    for (int i = 0; i < 350; i++) random_item();
    calm = 0;
    drain_and_config(4'($urandom_range(14, 2)));
    for (int i = 0; i < 400; i++) random_item();
    drain_and_config(4'd3);
    for (int i = 0; i < 400; i++) random_item();
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("PASS i2c_master_transaction_queue_unit");
    else $display("FAIL i2c_master_transaction_queue_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL i2c_master_transaction_queue_unit");
    $finish;
  end

endmodule

/* files.f */
rtl/i2cq_pkg.sv
rtl/i2cq_ram.sv
rtl/i2cq_front.sv
rtl/i2cq_back.sv
rtl/i2c_master_transaction_queue_unit.sv
rtl/i2cq_checker.sv
dv/i2cq_tb_pkg.sv
dv/i2cq_checker.sv
dv/i2c_master_transaction_queue_unit_tb.sv
